// ===== rtl/core/ilte_pkg.sv =====
// Shared types, widths and codes for the indexed list table engine.
// Every file of the block imports this package; it depends on nothing.
package ilte_pkg;

    // Number of list cells in the chain.
    localparam int DEPTH   = 64;

    // Field widths of the command and result transfers.
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 6;
    localparam int DATA_W  = 32;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 7;
    localparam int CAP_W   = 7;

    // Width of a cell position, and of the compare path that also holds DEPTH itself.
    localparam int POS_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W   = ((POS_W + 1) > CNT_W) ? (POS_W + 1) : CNT_W;

    // Capacity limit after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Command codes on the request channel.
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd7;

    // Status codes on the response channel.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Operations that travel down the cell chain.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_SET    = 3'd3;
    localparam logic [OP_W-1:0] OP_GET    = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

    // Token that walks the chain one cell per cycle and collects the result.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ST_W-1:0]          status;
        logic [CMP_W-1:0]         idx;
        logic [CMP_W-1:0]         n;
        logic [CMP_W-1:0]         cnt;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] carry;
        logic signed [DATA_W-1:0] rd;
        logic                     hit;
        logic [CMP_W-1:0]         hidx;
    } tok_t;

endpackage

// ===== rtl/core/ilte_if.sv =====
// Valid/ready channel interfaces for requests, responses and configuration.
// Depends on ilte_pkg for the field widths.

interface ilte_cmd_if import ilte_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, cmd, index, value, input ready);
    modport sink   (input valid, cmd, index, value, output ready);
endinterface

interface ilte_res_if import ilte_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] read_value;
    logic                     hit;
    logic [IDX_W-1:0]         hit_index;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;

    modport source (output valid, status, read_value, hit, hit_index, count, empty_res,
                    input ready);
    modport sink   (input valid, status, read_value, hit, hit_index, count, empty_res,
                    output ready);
endinterface

interface ilte_cfg_if import ilte_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity_limit;

    modport source (output valid, capacity_limit, input ready);
    modport sink   (input valid, capacity_limit, output ready);
endinterface

// ===== rtl/core/ilte_cell.sv =====
// One list cell: holds one entry and acts on the token as it passes by.
// Depends on ilte_pkg for the token type and operation codes.
module ilte_cell import ilte_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [POS_W-1:0]         pos,
    input  logic                     tok_in_valid,
    input  tok_t                     tok_in,
    input  logic signed [DATA_W-1:0] data_right,
    output logic                     tok_out_valid,
    output tok_t                     tok_out,
    output logic signed [DATA_W-1:0] data_out
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    tok_t                     tok_reg;
    tok_t                     tok_next;
    logic                     tok_valid_reg;
    logic [CMP_W-1:0]         pos_e;

    assign pos_e = CMP_W'(pos);

    // Apply the passing operation to this cell and update the token.
    always_comb
    begin
        tok_next  = tok_in;
        data_next = data_reg;
        if (tok_in_valid)
        begin
            unique case (tok_in.op)
                OP_INSERT:
                begin
                    // The new word lands here; every later live entry moves up by one.
                    if (pos_e == tok_in.idx)
                    begin
                        tok_next.carry = data_reg;
                        data_next      = tok_in.val;
                    end
                    else if ((pos_e > tok_in.idx) && (pos_e <= tok_in.n))
                    begin
                        tok_next.carry = data_reg;
                        data_next      = tok_in.carry;
                    end
                end
                OP_REMOVE:
                begin
                    // The right neighbor has not been touched yet, so its old entry moves down.
                    if (pos_e == tok_in.idx)
                    begin
                        tok_next.rd = data_reg;
                    end
                    if ((pos_e >= tok_in.idx) && ((pos_e + CMP_W'(1)) < tok_in.n))
                    begin
                        data_next = data_right;
                    end
                end
                OP_SET:
                begin
                    if (pos_e == tok_in.idx)
                    begin
                        data_next = tok_in.val;
                    end
                end
                OP_GET:
                begin
                    if (pos_e == tok_in.idx)
                    begin
                        tok_next.rd = data_reg;
                    end
                end
                OP_FIND:
                begin
                    // The first live match along the chain wins.
                    if (!tok_in.hit && (pos_e < tok_in.n) && (data_reg == tok_in.val))
                    begin
                        tok_next.hit  = 1'b1;
                        tok_next.hidx = pos_e;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // Token valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    // Entry and token payload.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        tok_reg  <= tok_next;
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;
    assign data_out      = data_reg;

endmodule

// ===== rtl/core/indexed_list_table_engine_core.sv =====
// Top level of the indexed list table engine: command decode, cell chain, result buffer.
// Depends on ilte_pkg, the interfaces in ilte_if and ilte_cell.
//
// Usage:
//   req carries one command (cmd, index, value); a transfer happens when valid and
//   ready are both high. rsp returns exactly one result per command, in order.
//   cfg writes capacity_limit; it is always ready and should be written while idle.
//   Each command is checked against the live count when it is taken, then a token
//   walks the chain of DEPTH cells, one cell per cycle, shifting, reading, writing
//   or comparing the entry in each cell on the way.
//   The result passes through the issue register, the DEPTH cells of the chain and
//   the output register before it is presented.
//   The block takes no new command while one is outstanding; req.ready returns
//   high in the same cycle that rsp.valid goes high with the result.
//   A stalled receiver does not stop the next command: the result of the next
//   command parks in a hold register until the output register frees up, and
//   req.ready stays low while that result waits.
//   Reset empties the list, sets capacity_limit to 16 and drops any command in
//   flight. Entries hold no reset value and are only read after they were written.
module indexed_list_table_engine_core import ilte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ilte_cmd_if.sink   req,
    ilte_res_if.source rsp,
    ilte_cfg_if.sink   cfg
);

    logic [CAP_W-1:0]  cap_reg;
    logic [CMP_W-1:0]  count_reg;
    logic [CMP_W-1:0]  count_next;
    logic              busy_reg;
    logic              busy_next;
    logic              issue_valid_reg;
    tok_t              issue_reg;
    tok_t              issue_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    tok_t              res_reg;
    tok_t              res_next;
    logic              hold_valid_reg;
    logic              hold_valid_next;
    tok_t              hold_reg;
    tok_t              hold_next;

    logic              req_xfer;
    logic              res_free;
    logic [CMP_W-1:0]  n_e;
    logic [CMP_W-1:0]  idx_e;
    logic [CMP_W-1:0]  cap_e;
    logic [CMP_W-1:0]  lim;

    logic                     cell_valid [0:DEPTH];
    tok_t                     cell_tok   [0:DEPTH];
    logic signed [DATA_W-1:0] cell_data  [0:DEPTH-1];

    assign req.ready = !busy_reg;
    assign req_xfer  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Effective capacity is the configured limit capped at the chain length.
    assign n_e   = count_reg;
    assign idx_e = CMP_W'(req.index);
    assign cap_e = CMP_W'(cap_reg);
    assign lim   = (cap_e > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_e;

    // Decode the command, check it against the count and build the token.
    always_comb
    begin
        issue_next        = '0;
        issue_next.status = ST_OK;
        issue_next.op     = OP_NOP;
        issue_next.idx    = idx_e;
        issue_next.n      = n_e;
        issue_next.val    = req.value;
        count_next        = count_reg;
        unique case (req.cmd)
            CMD_PUSH:
            begin
                if (n_e >= lim)
                begin
                    issue_next.status = ST_FULL;
                end
                else
                begin
                    issue_next.op  = OP_INSERT;
                    issue_next.idx = n_e;
                    count_next     = n_e + CMP_W'(1);
                end
            end
            CMD_POP:
            begin
                if (n_e == '0)
                begin
                    issue_next.status = ST_RANGE;
                end
                else
                begin
                    issue_next.op  = OP_GET;
                    issue_next.idx = n_e - CMP_W'(1);
                    count_next     = n_e - CMP_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (idx_e > n_e)
                begin
                    issue_next.status = ST_RANGE;
                end
                else if (n_e >= lim)
                begin
                    issue_next.status = ST_FULL;
                end
                else
                begin
                    issue_next.op = OP_INSERT;
                    count_next    = n_e + CMP_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (idx_e >= n_e)
                begin
                    issue_next.status = ST_RANGE;
                end
                else
                begin
                    issue_next.op = OP_REMOVE;
                    count_next    = n_e - CMP_W'(1);
                end
            end
            CMD_SET:
            begin
                if (idx_e >= n_e)
                begin
                    issue_next.status = ST_RANGE;
                end
                else
                begin
                    issue_next.op = OP_SET;
                end
            end
            CMD_GET:
            begin
                if (idx_e >= n_e)
                begin
                    issue_next.status = ST_RANGE;
                end
                else
                begin
                    issue_next.op = OP_GET;
                end
            end
            CMD_FIND:
            begin
                issue_next.op = OP_FIND;
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        issue_next.cnt = count_next;
    end

    // Cell chain: each cell sees the token of its left neighbor and the entry on its right.
    assign cell_valid[0] = issue_valid_reg;
    assign cell_tok[0]   = issue_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic signed [DATA_W-1:0] right_data;

        if (k == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[k];
        end
        else
        begin : g_mid
            assign right_data = cell_data[k+1];
        end

        ilte_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .pos           (POS_W'(k)),
            .tok_in_valid  (cell_valid[k]),
            .tok_in        (cell_tok[k]),
            .data_right    (right_data),
            .tok_out_valid (cell_valid[k+1]),
            .tok_out       (cell_tok[k+1]),
            .data_out      (cell_data[k])
        );
    end

    // Result buffering: the finished token goes to the output register, or waits in hold.
    assign res_free = !res_valid_reg || rsp.ready;

    always_comb
    begin
        res_valid_next  = res_valid_reg && !rsp.ready;
        res_next        = res_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        busy_next       = busy_reg || req_xfer;
        if (cell_valid[DEPTH])
        begin
            if (res_free)
            begin
                res_valid_next = 1'b1;
                res_next       = cell_tok[DEPTH];
                busy_next      = 1'b0;
            end
            else
            begin
                hold_valid_next = 1'b1;
                hold_next       = cell_tok[DEPTH];
            end
        end
        else if (hold_valid_reg && res_free)
        begin
            res_valid_next  = 1'b1;
            res_next        = hold_reg;
            hold_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg         <= CAP_RESET;
            count_reg       <= '0;
            busy_reg        <= 1'b0;
            issue_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
            hold_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.capacity_limit;
            end
            if (req_xfer)
            begin
                count_reg <= count_next;
            end
            busy_reg        <= busy_next;
            issue_valid_reg <= req_xfer;
            res_valid_reg   <= res_valid_next;
            hold_valid_reg  <= hold_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            issue_reg <= issue_next;
        end
        res_reg  <= res_next;
        hold_reg <= hold_next;
    end

    // Response fields.
    assign rsp.valid      = res_valid_reg;
    assign rsp.status     = res_reg.status;
    assign rsp.read_value = res_reg.rd;
    assign rsp.hit        = res_reg.hit;
    assign rsp.hit_index  = res_reg.hidx[IDX_W-1:0];
    assign rsp.count      = res_reg.cnt[CNT_W-1:0];
    assign rsp.empty_res  = (res_reg.cnt == '0);

    // A taken request starts its token down the chain in the next cycle.
    a_issue_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> cell_valid[0])
        else $error("accepted request did not enter the cell chain");

    // A token leaving the chain always belongs to an outstanding command.
    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[DEPTH] |-> busy_reg)
        else $error("token left the chain with no command outstanding");

    // The hold register and a leaving token never meet.
    a_hold_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(hold_valid_reg && cell_valid[DEPTH]))
        else $error("second result arrived while one is held");

    // The live count never passes the chain length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMP_W'(DEPTH))
        else $error("entry count exceeds the number of cells");

endmodule
